@@ hw/rtl/i2cee_pkg.sv @@
// ============================================================================
// i2cee_pkg
// Types and constants shared by the EEPROM byte-access I2C master.
// ============================================================================
package i2cee_pkg;

    // Command codes carried in s_tuser
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_SPARE = 2'd3;   // not decoded: plain tick

    // Configuration register indexes
    localparam logic [1:0] REG_SLAVE_ADDR         = 2'd0;
    localparam logic [1:0] REG_PHASE_TICKS        = 2'd1;
    localparam logic [1:0] REG_PROGRAM_WAIT_TICKS = 2'd2;

    localparam logic [6:0]  SLAVE_ADDR_RESET         = 7'd80;
    localparam logic [15:0] PHASE_TICKS_RESET        = 16'd50;
    localparam logic [23:0] PROGRAM_WAIT_TICKS_RESET = 24'd25000;

    localparam int unsigned BITS_PER_BYTE = 8;

    typedef enum logic [3:0] {
        SEG_IDLE   = 4'd0,
        SEG_START  = 4'd1,
        SEG_DEVW   = 4'd2,
        SEG_AHI    = 4'd3,
        SEG_ALO    = 4'd4,
        SEG_DATA   = 4'd5,
        SEG_RSTART = 4'd6,
        SEG_DEVR   = 4'd7,
        SEG_READ   = 4'd8,
        SEG_STOP   = 4'd9,
        SEG_WAIT   = 4'd10
    } seg_t;

    typedef struct packed {
        seg_t        seg;
        logic        half;          // SCL-high half of a bit slot
        logic [23:0] timer;
        logic [3:0]  bit_count;
        logic [7:0]  shift_byte;
        logic [15:0] lat_addr;
        logic [7:0]  lat_data;
        logic        is_read;
        logic        ack_missing;
        logic [7:0]  result_byte;
    } state_t;

    typedef struct packed {
        logic [23:0] program_wait_ticks;
        logic [15:0] phase_ticks;
        logic [6:0]  slave_addr;
    } cfg_t;

    typedef struct packed {
        logic       nack_flag;
        logic [7:0] read_data;
        logic       done_res;
        logic       busy_res;
        logic       sda_drive_low;
        logic       scl;
    } result_t;

endpackage

@@ hw/rtl/i2cee_step.sv @@
// ============================================================================
// i2cee_step
// One tick of the I2C sequencer: next state and pin levels for one word.
// ============================================================================
module i2cee_step (
    input  i2cee_pkg::state_t  cur,
    input  i2cee_pkg::cfg_t    cfg,
    input  logic [1:0]         cmd,
    input  logic [15:0]        byte_addr,
    input  logic [7:0]         write_data,
    input  logic               sda_in,
    output i2cee_pkg::state_t  nxt,
    output i2cee_pkg::result_t res
);

    function automatic i2cee_pkg::state_t enter_seg(
        input i2cee_pkg::seg_t   seg,
        input i2cee_pkg::state_t st,
        input logic [6:0]        dev
    );
        i2cee_pkg::state_t s;
        s           = st;
        s.seg       = seg;
        s.half      = 1'b0;
        s.bit_count = 4'd0;
        s.timer     = 24'd0;
        case (seg)
            i2cee_pkg::SEG_DEVW: s.shift_byte = {dev, 1'b0};
            i2cee_pkg::SEG_AHI:  s.shift_byte = st.lat_addr[15:8];
            i2cee_pkg::SEG_ALO:  s.shift_byte = st.lat_addr[7:0];
            i2cee_pkg::SEG_DATA: s.shift_byte = st.lat_data;
            i2cee_pkg::SEG_DEVR: s.shift_byte = {dev, 1'b1};
            i2cee_pkg::SEG_READ: s.shift_byte = 8'd0;
            default:             s.shift_byte = st.shift_byte;
        endcase
        return s;
    endfunction

    logic [15:0] plen;
    logic [24:0] timer_inc;
    logic        phase_over;
    logic        wait_over;
    logic        done;
    logic [7:0]  shifted;
    logic        cur_byte_seg;
    logic        nxt_byte_seg;

    assign plen       = (cfg.phase_ticks == 16'd0) ? 16'd1 : cfg.phase_ticks;
    assign timer_inc  = {1'b0, cur.timer} + 25'd1;
    assign phase_over = timer_inc >= {9'd0, plen};
    assign wait_over  = timer_inc >= {1'b0, cfg.program_wait_ticks};
    assign shifted    = {cur.shift_byte[6:0], sda_in};
    assign cur_byte_seg = cur.seg inside {i2cee_pkg::SEG_DEVW, i2cee_pkg::SEG_AHI,
                                          i2cee_pkg::SEG_ALO, i2cee_pkg::SEG_DATA,
                                          i2cee_pkg::SEG_DEVR, i2cee_pkg::SEG_READ};

    always_comb begin
        nxt  = cur;
        done = 1'b0;
        case (cur.seg)
            i2cee_pkg::SEG_IDLE: begin
                if (cmd == i2cee_pkg::CMD_WRITE || cmd == i2cee_pkg::CMD_READ) begin
                    nxt.lat_addr    = byte_addr;
                    nxt.lat_data    = write_data;
                    nxt.is_read     = (cmd == i2cee_pkg::CMD_READ);
                    nxt.ack_missing = 1'b0;
                    nxt = enter_seg(i2cee_pkg::SEG_START, nxt, cfg.slave_addr);
                end
            end
            i2cee_pkg::SEG_WAIT: begin
                if (wait_over) begin
                    nxt  = enter_seg(i2cee_pkg::SEG_IDLE, cur, cfg.slave_addr);
                    done = 1'b1;
                end else begin
                    nxt.timer = timer_inc[23:0];
                end
            end
            default: begin
                if (!phase_over) begin
                    nxt.timer = timer_inc[23:0];
                end else begin
                    nxt.timer = 24'd0;
                    if (cur.seg == i2cee_pkg::SEG_START) begin
                        if (cur.bit_count == 4'd0) begin
                            nxt.bit_count = 4'd1;
                        end else begin
                            nxt = enter_seg(i2cee_pkg::SEG_DEVW, cur, cfg.slave_addr);
                        end
                    end else if (cur.seg == i2cee_pkg::SEG_RSTART) begin
                        if (cur.bit_count < 4'd2) begin
                            nxt.bit_count = cur.bit_count + 4'd1;
                        end else begin
                            nxt = enter_seg(i2cee_pkg::SEG_DEVR, cur, cfg.slave_addr);
                        end
                    end else if (cur.seg == i2cee_pkg::SEG_STOP) begin
                        if (cur.bit_count < 4'd2) begin
                            nxt.bit_count = cur.bit_count + 4'd1;
                        end else if (cur.is_read || cfg.program_wait_ticks == 24'd0) begin
                            nxt  = enter_seg(i2cee_pkg::SEG_IDLE, cur, cfg.slave_addr);
                            done = 1'b1;
                        end else begin
                            nxt = enter_seg(i2cee_pkg::SEG_WAIT, cur, cfg.slave_addr);
                        end
                    end else if (!cur_byte_seg) begin
                        // unused segment codes fall back to idle
                        nxt = enter_seg(i2cee_pkg::SEG_IDLE, cur, cfg.slave_addr);
                    end else if (!cur.half) begin
                        nxt.half = 1'b1;
                    end else begin
                        // end of SCL high: sample ACK or data bit
                        if (cur.bit_count >= 4'd8) begin
                            if (cur.seg != i2cee_pkg::SEG_READ && sda_in) begin
                                nxt.ack_missing = 1'b1;
                            end
                        end else if (cur.seg == i2cee_pkg::SEG_READ) begin
                            nxt.shift_byte = shifted;
                            if (cur.bit_count == 4'd7) begin
                                nxt.result_byte = shifted;
                            end
                        end
                        nxt.bit_count = cur.bit_count + 4'd1;
                        nxt.half      = 1'b0;
                        if (cur.bit_count >= 4'd8) begin
                            case (cur.seg)
                                i2cee_pkg::SEG_DEVW:
                                    nxt = enter_seg(i2cee_pkg::SEG_AHI, nxt,
                                                    cfg.slave_addr);
                                i2cee_pkg::SEG_AHI:
                                    nxt = enter_seg(i2cee_pkg::SEG_ALO, nxt,
                                                    cfg.slave_addr);
                                i2cee_pkg::SEG_ALO:
                                    nxt = enter_seg(cur.is_read ? i2cee_pkg::SEG_RSTART
                                                                : i2cee_pkg::SEG_DATA,
                                                    nxt, cfg.slave_addr);
                                i2cee_pkg::SEG_DEVR:
                                    nxt = enter_seg(i2cee_pkg::SEG_READ, nxt,
                                                    cfg.slave_addr);
                                default:
                                    nxt = enter_seg(i2cee_pkg::SEG_STOP, nxt,
                                                    cfg.slave_addr);
                            endcase
                        end
                    end
                end
            end
        endcase
    end

    assign nxt_byte_seg = nxt.seg inside {i2cee_pkg::SEG_DEVW, i2cee_pkg::SEG_AHI,
                                          i2cee_pkg::SEG_ALO, i2cee_pkg::SEG_DATA,
                                          i2cee_pkg::SEG_DEVR, i2cee_pkg::SEG_READ};

    // Pin levels follow the state after this tick
    always_comb begin
        res.scl           = 1'b1;
        res.sda_drive_low = 1'b0;
        case (nxt.seg)
            i2cee_pkg::SEG_START: begin
                res.sda_drive_low = (nxt.bit_count == 4'd1);
            end
            i2cee_pkg::SEG_RSTART: begin
                res.scl           = (nxt.bit_count >= 4'd1);
                res.sda_drive_low = (nxt.bit_count == 4'd2);
            end
            i2cee_pkg::SEG_STOP: begin
                res.scl           = (nxt.bit_count >= 4'd1);
                res.sda_drive_low = (nxt.bit_count <= 4'd1);
            end
            default: begin
                if (nxt_byte_seg) begin
                    res.scl = nxt.half;
                    if (nxt.seg != i2cee_pkg::SEG_READ && nxt.bit_count < 4'd8) begin
                        res.sda_drive_low = ~nxt.shift_byte[3'd7 - nxt.bit_count[2:0]];
                    end
                end
            end
        endcase
        res.busy_res  = (nxt.seg != i2cee_pkg::SEG_IDLE);
        res.done_res  = done;
        res.read_data = nxt.result_byte;
        res.nack_flag = nxt.ack_missing;
    end

endmodule

@@ hw/rtl/i2c_eeprom_byte_access_master.sv @@
// ============================================================================
// i2c_eeprom_byte_access_master
// Tick-driven I2C master for byte writes and random reads of a 16-bit EEPROM.
// ============================================================================
// Every input word is one timer tick and may carry a command in s_tuser; the block
// takes one word per clock while s_tready is high (result register empty or being
// taken) and returns exactly one result word per input word through a registered
// output stage. The single sequencer state register advances once per accepted
// word. Configuration is written through cfg_we/cfg_index/cfg_wdata while idle;
// the user must keep to this, as the block itself does not enforce it.
module i2c_eeprom_byte_access_master (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_wdata,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // byte_addr[15:0], write_data[23:16], sda_in[24]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // scl[0], sda_drive_low[1], busy_res[2],
                                   // done_res[3], read_data[11:4], nack_flag[12]
);

    i2cee_pkg::cfg_t    cfg_reg;
    i2cee_pkg::state_t  state_reg;
    i2cee_pkg::state_t  state_next;
    i2cee_pkg::result_t res_next;
    i2cee_pkg::result_t res_reg;
    logic               m_tvalid_reg;
    logic               s_accept;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.slave_addr         <= i2cee_pkg::SLAVE_ADDR_RESET;
            cfg_reg.phase_ticks        <= i2cee_pkg::PHASE_TICKS_RESET;
            cfg_reg.program_wait_ticks <= i2cee_pkg::PROGRAM_WAIT_TICKS_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                i2cee_pkg::REG_SLAVE_ADDR:         cfg_reg.slave_addr <= cfg_wdata[6:0];
                i2cee_pkg::REG_PHASE_TICKS:        cfg_reg.phase_ticks <= cfg_wdata[15:0];
                i2cee_pkg::REG_PROGRAM_WAIT_TICKS: cfg_reg.program_wait_ticks <= cfg_wdata;
                default: ;
            endcase
        end
    end

    i2cee_step u_step (
        .cur         (state_reg),
        .cfg         (cfg_reg),
        .cmd         (s_tuser),
        .byte_addr   (s_tdata[15:0]),
        .write_data  (s_tdata[23:16]),
        .sda_in      (s_tdata[24]),
        .nxt         (state_next),
        .res         (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            res_reg      <= '0;
        end else begin
            if (s_accept) begin
                state_reg <= state_next;
                // result payload: hold until taken
                res_reg   <= res_next;
            end
            if (s_accept) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'd0, res_reg};

    // ------------------------------------------------------------------
    a_bit_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.bit_count <= 4'd9)
        else $error("bit counter out of range");

    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> !(res_reg.done_res && res_reg.busy_res))
        else $error("done reported while busy");

    a_idle_lines: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !res_reg.busy_res) |-> (res_reg.scl && !res_reg.sda_drive_low))
        else $error("bus not released while idle");

    a_cmd_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && state_reg.seg == i2cee_pkg::SEG_IDLE &&
         (s_tuser == i2cee_pkg::CMD_WRITE || s_tuser == i2cee_pkg::CMD_READ))
        |=> (m_tvalid_reg && res_reg.busy_res && !res_reg.nack_flag))
        else $error("command did not start a transfer");

endmodule

@@ tb/sv/i2c_eeprom_byte_access_master_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_eeprom_byte_access_master_checker
// Watches the configuration port and both streams of the EEPROM I2C master.
// A cycle-free copy of the bit sequencer advances for every input word taken,
// and every field it predicts is compared with the matching result word.
// ----------------------------------------------------------------------------
module i2c_eeprom_byte_access_master_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    output int          error_count,
    output int          pins_outstanding
);

    // settings as the block holds them
    logic [6:0]  dev_addr;
    logic [15:0] phase_len;
    logic [23:0] prog_wait;

    // sequencer copy
    i2cee_pkg::seg_t seg_now;
    logic        hi_half;
    logic [23:0] tick_count;
    logic [3:0]  bit_idx;
    logic [7:0]  shreg;
    logic [15:0] addr_hold;
    logic [7:0]  data_hold;
    logic        reading;
    logic        nack_seen;
    logic [7:0]  last_read;

    i2cee_pkg::result_t pins_due[$];

    function automatic logic is_byte_seg(input i2cee_pkg::seg_t s);
        return (s == i2cee_pkg::SEG_DEVW) || (s == i2cee_pkg::SEG_AHI) ||
               (s == i2cee_pkg::SEG_ALO) || (s == i2cee_pkg::SEG_DATA) ||
               (s == i2cee_pkg::SEG_DEVR) || (s == i2cee_pkg::SEG_READ);
    endfunction

    function automatic void enter_seg(input i2cee_pkg::seg_t s);
        seg_now    = s;
        hi_half    = 1'b0;
        bit_idx    = '0;
        tick_count = '0;
        case (s)
            i2cee_pkg::SEG_DEVW: shreg = {dev_addr, 1'b0};
            i2cee_pkg::SEG_AHI:  shreg = addr_hold[15:8];
            i2cee_pkg::SEG_ALO:  shreg = addr_hold[7:0];
            i2cee_pkg::SEG_DATA: shreg = data_hold;
            i2cee_pkg::SEG_DEVR: shreg = {dev_addr, 1'b1};
            i2cee_pkg::SEG_READ: shreg = '0;
            default: ;
        endcase
    endfunction

    // End of one SCL phase; returns 1 when a transfer finishes here.
    function automatic logic close_phase(input logic sda);
        logic fin;
        fin        = 1'b0;
        tick_count = '0;
        case (seg_now)
            i2cee_pkg::SEG_START: begin
                if (bit_idx == 0) bit_idx = 4'd1;
                else enter_seg(i2cee_pkg::SEG_DEVW);
            end
            i2cee_pkg::SEG_RSTART: begin
                if (bit_idx < 2) bit_idx = bit_idx + 4'd1;
                else enter_seg(i2cee_pkg::SEG_DEVR);
            end
            i2cee_pkg::SEG_STOP: begin
                if (bit_idx < 2) begin
                    bit_idx = bit_idx + 4'd1;
                end else if (reading || prog_wait == 0) begin
                    enter_seg(i2cee_pkg::SEG_IDLE);
                    fin = 1'b1;
                end else begin
                    enter_seg(i2cee_pkg::SEG_WAIT);
                end
            end
            default: begin
                if (!hi_half) begin
                    hi_half = 1'b1;
                end else begin
                    // sample on the last tick of the high half
                    if (bit_idx >= 8) begin
                        if (seg_now != i2cee_pkg::SEG_READ && sda) nack_seen = 1'b1;
                    end else if (seg_now == i2cee_pkg::SEG_READ) begin
                        shreg = {shreg[6:0], sda};
                        if (bit_idx == 7) last_read = shreg;
                    end
                    bit_idx = bit_idx + 4'd1;
                    hi_half = 1'b0;
                    if (bit_idx > 8) begin
                        case (seg_now)
                            i2cee_pkg::SEG_DEVW: enter_seg(i2cee_pkg::SEG_AHI);
                            i2cee_pkg::SEG_AHI:  enter_seg(i2cee_pkg::SEG_ALO);
                            i2cee_pkg::SEG_ALO:
                                enter_seg(reading ? i2cee_pkg::SEG_RSTART
                                                  : i2cee_pkg::SEG_DATA);
                            i2cee_pkg::SEG_DEVR: enter_seg(i2cee_pkg::SEG_READ);
                            default:             enter_seg(i2cee_pkg::SEG_STOP);
                        endcase
                    end
                end
            end
        endcase
        return fin;
    endfunction

    task automatic advance_tick(input logic [1:0] cmd, input logic [15:0] addr,
                                input logic [7:0] wdata, input logic sda);
        int unsigned        span;
        logic               fin;
        i2cee_pkg::result_t r;
        fin  = 1'b0;
        span = (phase_len == 16'd0) ? 32'd1 : {16'd0, phase_len};
        if (seg_now == i2cee_pkg::SEG_IDLE) begin
            if (cmd == i2cee_pkg::CMD_WRITE || cmd == i2cee_pkg::CMD_READ) begin
                addr_hold = addr;
                data_hold = wdata;
                reading   = (cmd == i2cee_pkg::CMD_READ);
                nack_seen = 1'b0;
                enter_seg(i2cee_pkg::SEG_START);
            end
        end else if (seg_now == i2cee_pkg::SEG_WAIT) begin
            if (tick_count + 32'd1 >= prog_wait) begin
                enter_seg(i2cee_pkg::SEG_IDLE);
                fin = 1'b1;
            end else begin
                tick_count = tick_count + 24'd1;
            end
        end else if (tick_count + 32'd1 >= span) begin
            fin = close_phase(sda);
        end else begin
            tick_count = tick_count + 24'd1;
        end

        r.scl           = 1'b1;
        r.sda_drive_low = 1'b0;
        case (seg_now)
            i2cee_pkg::SEG_START: r.sda_drive_low = (bit_idx == 1);
            i2cee_pkg::SEG_RSTART: begin
                r.scl           = (bit_idx >= 1);
                r.sda_drive_low = (bit_idx == 2);
            end
            i2cee_pkg::SEG_STOP: begin
                r.scl           = (bit_idx >= 1);
                r.sda_drive_low = (bit_idx <= 1);
            end
            default: begin
                if (is_byte_seg(seg_now)) begin
                    r.scl = hi_half;
                    if (seg_now != i2cee_pkg::SEG_READ && bit_idx < 8)
                        r.sda_drive_low = !shreg[3'd7 - bit_idx[2:0]];
                end
            end
        endcase
        r.busy_res  = (seg_now != i2cee_pkg::SEG_IDLE);
        r.done_res  = fin;
        r.read_data = last_read;
        r.nack_flag = nack_seen;
        pins_due.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= 40)
            $display("%0t ns: mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    endtask

    task automatic check_word(input i2cee_pkg::result_t got);
        i2cee_pkg::result_t want;
        if (pins_due.size() == 0) begin
            report_mismatch("word with nothing pending", int'(got), 0);
        end else begin
            want = pins_due.pop_front();
            if (got.scl !== want.scl)
                report_mismatch("scl", int'(got.scl), int'(want.scl));
            if (got.sda_drive_low !== want.sda_drive_low)
                report_mismatch("sda_drive_low", int'(got.sda_drive_low),
                                int'(want.sda_drive_low));
            if (got.busy_res !== want.busy_res)
                report_mismatch("busy_res", int'(got.busy_res), int'(want.busy_res));
            if (got.done_res !== want.done_res)
                report_mismatch("done_res", int'(got.done_res), int'(want.done_res));
            if (got.read_data !== want.read_data)
                report_mismatch("read_data", int'(got.read_data), int'(want.read_data));
            if (got.nack_flag !== want.nack_flag)
                report_mismatch("nack_flag", int'(got.nack_flag), int'(want.nack_flag));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr    = i2cee_pkg::SLAVE_ADDR_RESET;
            phase_len   = i2cee_pkg::PHASE_TICKS_RESET;
            prog_wait   = i2cee_pkg::PROGRAM_WAIT_TICKS_RESET;
            seg_now     = i2cee_pkg::SEG_IDLE;
            hi_half     = 1'b0;
            tick_count  = '0;
            bit_idx     = '0;
            shreg       = '0;
            addr_hold   = '0;
            data_hold   = '0;
            reading     = 1'b0;
            nack_seen   = 1'b0;
            last_read   = '0;
            error_count = 0;
            pins_due.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    i2cee_pkg::REG_SLAVE_ADDR:         dev_addr  = cfg_wdata[6:0];
                    i2cee_pkg::REG_PHASE_TICKS:        phase_len = cfg_wdata[15:0];
                    i2cee_pkg::REG_PROGRAM_WAIT_TICKS: prog_wait = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                advance_tick(s_tuser, s_tdata[15:0], s_tdata[23:16], s_tdata[24]);
            if (m_tvalid && m_tready)
                check_word(m_tdata[12:0]);
        end
        pins_outstanding = pins_due.size();
    end

endmodule

@@ tb/sv/i2c_eeprom_byte_access_master_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_eeprom_byte_access_master_test
// Drives tick words and byte write / random read commands into the EEPROM I2C
// master under several bus timings and handshake idling patterns; the checker
// beside the block predicts every result word and counts mismatches.
// ----------------------------------------------------------------------------
module i2c_eeprom_byte_access_master_test;

    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 400;
    localparam int STRETCH_WORDS = 280;

    // how SDA is answered during a transfer
    localparam int SDA_ACK_ALL  = 0;
    localparam int SDA_NACK_ALL = 1;
    localparam int SDA_SPARSE   = 2;
    localparam int SDA_NOISY    = 3;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // byte_addr[15:0], write_data[23:16], sda_in[24]
    logic [1:0]  s_tuser;   // cmd[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // scl[0], sda_drive_low[1], busy_res[2], done_res[3],
                            // read_data[11:4], nack_flag[12]

    int          error_count;
    int          pins_outstanding;
    int          words_sent;
    int          idle_pct;
    int          stall_pct;
    int          sda_mode;
    int          quiet_cycles;
    int unsigned phase_now;
    int unsigned wait_now;
    logic        hold_request;
    logic        hold_done;

    i2c_eeprom_byte_access_master DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    i2c_eeprom_byte_access_master_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .error_count      (error_count),
        .pins_outstanding (pins_outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin : result_sink
        m_tready  = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request && !hold_done) begin
                // hold off long enough for the block to back up into its input
                m_tready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) @(negedge aclk);
                hold_done = 1'b1;
            end
            m_tready <= (int'($urandom_range(99)) >= stall_pct);
        end
    end

    initial begin : watchdog
        quiet_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("i2c_eeprom_byte_access_master_test: done, errors");
                $finish;
            end
        end
    end

    function automatic logic sda_level();
        case (sda_mode)
            SDA_ACK_ALL:  return 1'b0;
            SDA_NACK_ALL: return 1'b1;
            SDA_SPARSE:   return ($urandom_range(7) == 0);
            default:      return 1'($urandom_range(1));
        endcase
    endfunction

    // commands that an idle block must treat as plain ticks
    function automatic logic [1:0] idle_cmd();
        return $urandom_range(1) ? i2cee_pkg::CMD_TICK : i2cee_pkg::CMD_SPARE;
    endfunction

    // mostly ticks, now and then a command the busy block has to ignore
    function automatic logic [1:0] busy_cmd();
        logic [1:0] c;
        c = 2'($urandom_range(3));
        return ($urandom_range(15) == 0) ? c : i2cee_pkg::CMD_TICK;
    endfunction

    task automatic push_word(input logic [1:0] cmd, input logic [15:0] addr,
                             input logic [7:0] data, input logic sda);
        while (int'($urandom_range(99)) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {7'd0, sda, data, addr};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        words_sent++;
    endtask

    task automatic idle_ticks(input int n);
        repeat (n) push_word(idle_cmd(), 16'($urandom_range(16'hFFFF)),
                             8'($urandom_range(8'hFF)), 1'($urandom_range(1)));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pins_outstanding != 0);
    endtask

    task automatic apply_settings(input logic [6:0] dev, input logic [15:0] ph,
                                  input logic [23:0] pw);
        cfg_we    <= 1'b1;
        cfg_index <= i2cee_pkg::REG_SLAVE_ADDR;
        cfg_wdata <= {17'd0, dev};
        @(negedge aclk);
        cfg_index <= i2cee_pkg::REG_PHASE_TICKS;
        cfg_wdata <= {8'd0, ph};
        @(negedge aclk);
        cfg_index <= i2cee_pkg::REG_PROGRAM_WAIT_TICKS;
        cfg_wdata <= pw;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        phase_now = (ph == 16'd0) ? 32'd1 : {16'd0, ph};
        wait_now  = {8'd0, pw};
    endtask

    // One command and enough ticks to see it through, plus a short idle tail.
    task automatic run_transfer(input logic [1:0] op, input logic [15:0] addr,
                                input logic [7:0] data);
        int unsigned span;
        span = (op == i2cee_pkg::CMD_READ) ? 98 * phase_now : 77 * phase_now + wait_now;
        push_word(op, addr, data, sda_level());
        for (int unsigned k = 1; k <= span; k++)
            push_word((k + 2 <= span) ? busy_cmd() : i2cee_pkg::CMD_TICK,
                      16'($urandom_range(16'hFFFF)), 8'($urandom_range(8'hFF)),
                      sda_level());
        idle_ticks(1 + int'($urandom_range(3)));
    endtask

    task automatic random_stretch(input int quota, input logic reads_only);
        int         stop_at;
        int         pick;
        logic [1:0] op;
        stop_at = words_sent + quota;
        while (words_sent < stop_at) begin
            op   = (reads_only || $urandom_range(1)) ? i2cee_pkg::CMD_READ
                                                     : i2cee_pkg::CMD_WRITE;
            pick = int'($urandom_range(99));
            sda_mode = (pick < 50) ? SDA_ACK_ALL : (pick < 75) ? SDA_SPARSE :
                       (pick < 90) ? SDA_NOISY : SDA_NACK_ALL;
            run_transfer(op, 16'($urandom_range(16'hFFFF)), 8'($urandom_range(8'hFF)));
        end
    endtask

    initial begin : stimulus
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = i2cee_pkg::REG_SLAVE_ADDR;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = i2cee_pkg::CMD_TICK;
        idle_pct     = 0;
        stall_pct    = 0;
        sda_mode     = SDA_ACK_ALL;
        hold_request = 1'b0;
        words_sent   = 0;
        phase_now    = {16'd0, i2cee_pkg::PHASE_TICKS_RESET};
        wait_now     = {8'd0, i2cee_pkg::PROGRAM_WAIT_TICKS_RESET};
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset settings, idle only
        idle_ticks(4);
        drain();

        // lowest address and timing, clean acks then all NACKs
        apply_settings(7'd0, 16'd1, 24'd0);
        sda_mode = SDA_ACK_ALL;
        run_transfer(i2cee_pkg::CMD_WRITE, 16'h0000, 8'h00);
        sda_mode = SDA_NACK_ALL;
        run_transfer(i2cee_pkg::CMD_READ, 16'hFFFF, 8'h00);
        drain();

        // zero phase length acts as one tick
        apply_settings(7'd127, 16'd0, 24'd1);
        sda_mode = SDA_NOISY;
        run_transfer(i2cee_pkg::CMD_WRITE, 16'hFFFF, 8'hFF);
        run_transfer(i2cee_pkg::CMD_READ, 16'h0000, 8'hA5);
        drain();

        // largest timings: no transfer would finish, so idle only
        apply_settings(7'd85, 16'hFFFF, 24'hFFFFFF);
        idle_ticks(20);
        drain();

        apply_settings(7'($urandom_range(127)), 16'd1, 24'($urandom_range(20)));
        hold_request = 1'b1;
        random_stretch(STRETCH_WORDS, 1'b0);
        drain();

        apply_settings(7'($urandom_range(127)), 16'd2, 24'($urandom_range(20)));
        idle_pct = 84;
        random_stretch(STRETCH_WORDS, 1'b0);
        drain();

        apply_settings(7'($urandom_range(127)), 16'd3, 24'($urandom_range(20)));
        idle_pct  = 0;
        stall_pct = 84;
        random_stretch(STRETCH_WORDS, 1'b0);
        drain();

        // longest programming wait never applies to reads
        apply_settings(7'($urandom_range(127)), 16'd1, 24'hFFFFFF);
        idle_pct  = 13;
        stall_pct = 13;
        random_stretch(STRETCH_WORDS, 1'b1);

        s_tvalid <= 1'b0;
        while (pins_outstanding != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (error_count == 0) begin
            $display("i2c_eeprom_byte_access_master_test: done, clean");
        end else begin
            $display("i2c_eeprom_byte_access_master_test: done, errors");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/i2cee_pkg.sv
hw/rtl/i2cee_step.sv
hw/rtl/i2c_eeprom_byte_access_master.sv
tb/sv/i2c_eeprom_byte_access_master_checker.sv
tb/sv/i2c_eeprom_byte_access_master_test.sv
